[rtl/ulwt_pkg.sv]
package ulwt_pkg;

    // Fixed field widths
    localparam int ADDR_W     = 16;
    localparam int MODE_W     = 3;
    localparam int ACTION_W   = 3;
    localparam int COUNT_W    = 12;
    localparam int EPOCH_W    = 8;
    localparam int SIZE_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

    // Request modes
    localparam logic [MODE_W-1:0] MODE_RANGED = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CHECK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOG    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CKPT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RBEGIN = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RPOP   = 3'd5;

    // Result actions
    localparam logic [ACTION_W-1:0] ACT_SKIP     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_BACKUP   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RESTORE  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_OVERFLOW = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_EMPTY    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_EPOCH    = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHADOW_OFFSET = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
    } in_item_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   block_addr;
        logic [ADDR_W-1:0]   shadow_addr;
        logic [COUNT_W-1:0]  log_count;
        logic [EPOCH_W-1:0]  epoch_now;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_LOOK,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_start;
    } tag_ctl_t;

    typedef struct packed {
        logic rd_en;
        logic push;
        logic pop;
        logic clear;
    } log_ctl_t;

endpackage

[rtl/ulwt_tag_map.sv]
module ulwt_tag_map
    import ulwt_pkg::*;
#(
    parameter int ENTRIES = 256,
    parameter int AW      = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tag_ctl_t           ctl,
    input  logic [AW-1:0]      rd_addr,
    input  logic [AW-1:0]      wr_addr,
    input  logic [EPOCH_W-1:0] wr_data,
    output logic [EPOCH_W-1:0] rd_data,
    output logic               busy
);

    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    logic [EPOCH_W-1:0] mem [ENTRIES];
    logic [EPOCH_W-1:0] rd_data_reg;
    logic               busy_reg;
    logic               busy_next;
    logic [AW-1:0]      sweep_reg;
    logic [AW-1:0]      sweep_next;

    // Sweep control: clears one entry per cycle after reset and on request
    always_comb begin
        busy_next  = busy_reg;
        sweep_next = sweep_reg;
        if (busy_reg) begin
            sweep_next = sweep_reg + AW'(1);
            if (sweep_reg == LAST) begin
                busy_next = 1'b0;
            end
        end else if (ctl.clr_start) begin
            busy_next  = 1'b1;
            sweep_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            sweep_reg <= sweep_next;
        end
    end

    // Tag storage, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[sweep_reg] <= '0;
        end else if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

`ifndef SYNTHESIS
    a_no_write_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.wr_en |-> !busy_reg)
        else $error("tag write during clear sweep");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clr_start |-> !busy_reg)
        else $error("clear requested while sweeping");
    a_sweep_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && sweep_reg == LAST) |=> !busy_reg)
        else $error("sweep did not end at last entry");
`endif

endmodule

[rtl/ulwt_undo_log.sv]
module ulwt_undo_log
    import ulwt_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int AW     = 11,
    parameter int FILL_W = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  log_ctl_t          ctl,
    input  logic [ADDR_W-1:0] wr_data,
    output logic [ADDR_W-1:0] rd_data,
    output logic [FILL_W-1:0] fill
);

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] rd_data_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] top_idx;

    assign top_idx = fill_reg - FILL_W'(1);

    // Fill count: push, pop or clear
    always_comb begin
        fill_next = fill_reg;
        if (ctl.clear) begin
            fill_next = '0;
        end else if (ctl.push) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (ctl.pop) begin
            fill_next = top_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // Push at the fill point, read the top entry
    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            mem[fill_reg[AW-1:0]] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[top_idx[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;
    assign fill    = fill_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(DEPTH))
        else $error("undo log fill beyond depth");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.push |-> (fill_reg < FILL_W'(DEPTH)))
        else $error("push into full undo log");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pop |-> (fill_reg != '0))
        else $error("pop from empty undo log");
`endif

endmodule

[rtl/undo_log_write_tracker_unit.sv]
// Results are registered: with BLOCK_BYTES a power of two, an accepted request goes
//   to the execute step and then the output register; otherwise it first passes the
//   divide, fix-up and tag re-read steps. A new request is taken only in the idle step,
//   so one is in flight at a time; results wait in an output register.
// Reset: synchronous, active low; the tag map is then swept with no input taken,
//   and the same sweep follows every epoch wrap.
module undo_log_write_tracker_unit
    import ulwt_pkg::*;
#(
    parameter int MAP_ENTRIES = 256,
    parameter int LOG_DEPTH   = 2048,
    parameter int BLOCK_BYTES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    localparam int MAP_AW  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int MAP_CW  = $clog2(MAP_ENTRIES + 1);
    localparam int LOG_AW  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int FILL_W  = $clog2(LOG_DEPTH + 1);
    localparam int QW      = $clog2(65536 / BLOCK_BYTES + 1);
    localparam int IDX_CW  = (QW > MAP_CW) ? QW : MAP_CW;
    localparam int BLK_SH  = $clog2(BLOCK_BYTES);
    localparam bit BLK_POW2 = ((BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0);
    localparam logic [ADDR_W-1:0] BLK_SIZE = ADDR_W'(BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] BLK_MASK = ADDR_W'(BLOCK_BYTES - 1);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BLOCK_BYTES);

    // Configuration registers
    logic [ADDR_W-1:0] region_start_reg;
    logic [SIZE_W-1:0] region_size_reg;
    logic [ADDR_W-1:0] shadow_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_start_reg <= '0;
            region_size_reg  <= SIZE_W'(2048);
            shadow_off_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_REGION_START:  region_start_reg <= cfg_wdata;
                REG_REGION_SIZE:   region_size_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_SHADOW_OFFSET: shadow_off_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    state_t             state_reg, state_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    out_item_t          out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    logic               s_fire;
    logic               out_free;

    // Front end: range check and block/index for power-of-two blocks
    logic [ADDR_W-1:0]  rel_in;
    logic signed [17:0] last_in;
    logic               in_range_in;
    logic [ADDR_W-1:0]  blk_in;
    logic [QW-1:0]      idx_in;

    assign s_fire      = s_valid && s_ready;
    assign rel_in      = s_data.addr - region_start_reg;
    assign last_in     = signed'({2'b00, region_start_reg})
                       + signed'({6'b000000, region_size_reg}) - 18'sd2;
    assign in_range_in = (s_data.addr >= region_start_reg)
                      && (signed'({2'b00, s_data.addr}) <= last_in);
    assign blk_in      = s_data.addr & ~BLK_MASK;
    assign idx_in      = QW'(rel_in >> BLK_SH);

    logic [MODE_W-1:0] mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] rel_reg;
    logic              in_range_reg;
    logic [ADDR_W-1:0] blk_reg;
    logic [QW-1:0]     idx_reg;
    logic [QW-1:0]     qa_reg;
    logic [QW-1:0]     qr_reg;

    // Reciprocal divide for other block sizes: estimate, then one correction
    logic [47:0]       prod_a, prod_r;
    logic [ADDR_W-1:0] ma, ra, mr, rr;
    logic [ADDR_W-1:0] blk_fix;
    logic [QW-1:0]     idx_fix;

    assign prod_a  = 48'(addr_reg) * 48'(RECIP);
    assign prod_r  = 48'(rel_reg) * 48'(RECIP);
    assign ma      = ADDR_W'(qa_reg * BLOCK_BYTES);
    assign ra      = addr_reg - ma;
    assign blk_fix = (ra >= BLK_SIZE) ? ma + BLK_SIZE : ma;
    assign mr      = ADDR_W'(qr_reg * BLOCK_BYTES);
    assign rr      = rel_reg - mr;
    assign idx_fix = (rr >= BLK_SIZE) ? qr_reg + QW'(1) : qr_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg     <= s_data.mode;
            addr_reg     <= s_data.addr;
            rel_reg      <= rel_in;
            in_range_reg <= in_range_in;
            blk_reg      <= blk_in;
            idx_reg      <= idx_in;
        end
        if (state_reg == ST_DIV) begin
            qa_reg <= QW'(prod_a[47:32]);
            qr_reg <= QW'(prod_r[47:32]);
        end
        if (state_reg == ST_FIX) begin
            blk_reg <= blk_fix;
            idx_reg <= idx_fix;
        end
    end

    // Memory address selection
    logic [QW-1:0]     tag_rd_q;
    logic [IDX_CW-1:0] tag_rd_ext;
    logic [IDX_CW-1:0] idx_ext;
    logic              in_map;

    assign tag_rd_q   = (state_reg == ST_IDLE) ? idx_in : idx_reg;
    assign tag_rd_ext = IDX_CW'(tag_rd_q);
    assign idx_ext    = IDX_CW'(idx_reg);
    assign in_map     = idx_ext < IDX_CW'(MAP_ENTRIES);

    tag_ctl_t           tag_ctl;
    logic [EPOCH_W-1:0] tag_rd_data;
    logic               tag_busy;
    log_ctl_t           log_ctl;
    logic [ADDR_W-1:0]  log_rd_data;
    logic [FILL_W-1:0]  fill;

    ulwt_tag_map #(
        .ENTRIES (MAP_ENTRIES),
        .AW      (MAP_AW)
    ) u_tag_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (tag_ctl),
        .rd_addr (tag_rd_ext[MAP_AW-1:0]),
        .wr_addr (idx_ext[MAP_AW-1:0]),
        .wr_data (epoch_reg),
        .rd_data (tag_rd_data),
        .busy    (tag_busy)
    );

    ulwt_undo_log #(
        .DEPTH  (LOG_DEPTH),
        .AW     (LOG_AW),
        .FILL_W (FILL_W)
    ) u_undo_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (log_ctl),
        .wr_data (blk_reg),
        .rd_data (log_rd_data),
        .fill    (fill)
    );

    logic               tag_hit;
    logic               log_full;
    logic [EPOCH_W-1:0] epoch_inc;
    logic [ACTION_W-1:0] act;
    logic               named;
    logic [ADDR_W-1:0]  baddr;
    logic [FILL_W-1:0]  fill_after;
    logic               try_en;
    logic               try_chk;
    logic               adv;
    logic               rd_issue;

    assign tag_hit   = in_map && (tag_rd_data == epoch_reg);
    assign log_full  = fill >= FILL_W'(LOG_DEPTH);
    assign epoch_inc = epoch_reg + EPOCH_W'(1);
    assign out_free  = !m_valid_reg || m_ready;
    assign rd_issue  = s_fire || (state_reg == ST_LOOK);

    // Sequencer: read at accept (or after the divide), decide and write back
    always_comb begin
        state_next   = state_reg;
        epoch_next   = epoch_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        tag_ctl      = '0;
        log_ctl      = '0;
        tag_ctl.rd_en = rd_issue;
        log_ctl.rd_en = rd_issue;
        act        = ACT_SKIP;
        named      = 1'b0;
        baddr      = '0;
        fill_after = fill;
        try_en     = 1'b0;
        try_chk    = 1'b0;
        adv        = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                if (!tag_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = BLK_POW2 ? ST_EXEC : ST_DIV;
                end
            end
            ST_DIV:  state_next = ST_FIX;
            ST_FIX:  state_next = ST_LOOK;
            ST_LOOK: state_next = ST_EXEC;
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    case (mode_reg)
                        MODE_RANGED: begin
                            named = 1'b1;
                            baddr = blk_reg;
                            if (in_range_reg) begin
                                try_en  = 1'b1;
                                try_chk = 1'b1;
                            end
                        end
                        MODE_CHECK: begin
                            named   = 1'b1;
                            baddr   = blk_reg;
                            try_en  = 1'b1;
                            try_chk = 1'b1;
                        end
                        MODE_LOG: begin
                            named  = 1'b1;
                            baddr  = blk_reg;
                            try_en = 1'b1;
                        end
                        MODE_CKPT: begin
                            log_ctl.clear = 1'b1;
                            fill_after    = '0;
                            adv           = 1'b1;
                            act           = ACT_EPOCH;
                        end
                        MODE_RBEGIN: begin
                            adv = 1'b1;
                            act = ACT_EPOCH;
                        end
                        MODE_RPOP: begin
                            if (fill == '0) begin
                                act = ACT_EMPTY;
                            end else begin
                                log_ctl.pop = 1'b1;
                                fill_after  = fill - FILL_W'(1);
                                named       = 1'b1;
                                baddr       = log_rd_data;
                                act         = ACT_RESTORE;
                            end
                        end
                        default: ;
                    endcase

                    // Backup request: skip if checked and tagged this epoch, overflow if the log is full, else log it
                    if (try_en) begin
                        if (try_chk && tag_hit) begin
                            act = ACT_SKIP;
                        end else if (log_full) begin
                            act = ACT_OVERFLOW;
                        end else begin
                            act            = ACT_BACKUP;
                            log_ctl.push   = 1'b1;
                            fill_after     = fill + FILL_W'(1);
                            tag_ctl.wr_en  = in_map;
                        end
                    end

                    // New epoch; on wrap restart at one and sweep the map
                    if (adv) begin
                        if (epoch_inc == '0) begin
                            epoch_next        = EPOCH_ONE;
                            tag_ctl.clr_start = 1'b1;
                            state_next        = ST_CLEAR;
                        end else begin
                            epoch_next = epoch_inc;
                        end
                    end

                    out_next.action      = act;
                    out_next.block_addr  = baddr;
                    out_next.shadow_addr = named ? baddr - shadow_off_reg : '0;
                    out_next.log_count   = COUNT_W'(fill_after);
                    out_next.epoch_now   = epoch_next;
                    m_valid_next         = 1'b1;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            epoch_reg   <= EPOCH_ONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            epoch_reg   <= epoch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result raised outside execute step");
    a_epoch_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        epoch_reg != '0)
        else $error("epoch reached zero");
    a_tag_write_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        tag_ctl.wr_en |-> in_map)
        else $error("tag write outside map");
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        tag_busy |-> !s_ready)
        else $error("input taken during tag sweep");
`endif

endmodule

[tb/sv/undo_log_write_tracker_checker.sv]
// Watches both channels of the write tracker, keeps its own copy of the
// tracker state and configuration, and compares every result transaction
// against the outcome predicted for the oldest outstanding request.
module undo_log_write_tracker_checker
    import ulwt_pkg::*;
#(
    parameter int MAP_ENTRIES = 256,
    parameter int LOG_DEPTH   = 2048,
    parameter int BLOCK_BYTES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    output int unsigned           mismatches,
    output int unsigned           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the configuration registers
    logic [ADDR_W-1:0] region_base = '0;
    logic [SIZE_W-1:0] region_len  = SIZE_W'(2048);
    logic [ADDR_W-1:0] shadow_dist = '0;

    // Shadow copy of the tracker state
    logic [EPOCH_W-1:0] cur_epoch = EPOCH_ONE;
    logic [EPOCH_W-1:0] block_tag [MAP_ENTRIES];
    logic [ADDR_W-1:0]  undo_stack [LOG_DEPTH];
    int                 stack_fill = 0;

    // Outcomes of accepted requests, oldest first
    out_item_t tracker_outcomes [$];

    int unsigned n_issued  = 0;
    int unsigned n_retired = 0;
    int unsigned n_bad     = 0;

    assign outstanding = n_issued - n_retired;
    assign mismatches  = n_bad;

    // New epoch; a wrap to zero wipes every tag and restarts at one
    function automatic void bump_epoch();
        cur_epoch = cur_epoch + 1'b1;
        if (cur_epoch == '0) begin
            foreach (block_tag[i]) block_tag[i] = '0;
            cur_epoch = EPOCH_ONE;
        end
    endfunction

    // Push a block onto the undo log unless tags are honoured and it is already tagged this epoch, or the log is full
    function automatic logic [ACTION_W-1:0] save_block(input logic [ADDR_W-1:0] addr,
                                                       input bit honor_tag,
                                                       input logic [ADDR_W-1:0] blk);
        logic [ADDR_W-1:0] rel;
        int                idx;
        bit                in_map;
        rel    = addr - region_base;
        idx    = int'(rel) / BLOCK_BYTES;
        in_map = idx < MAP_ENTRIES;
        if (honor_tag && in_map && block_tag[idx] == cur_epoch) return ACT_SKIP;
        if (stack_fill >= LOG_DEPTH) return ACT_OVERFLOW;
        undo_stack[stack_fill] = blk;
        stack_fill++;
        if (in_map) block_tag[idx] = cur_epoch;
        return ACT_BACKUP;
    endfunction

    // Apply one request to the shadow state and return the result it causes
    function automatic out_item_t track_store(input in_item_t req);
        out_item_t         res;
        logic [ADDR_W-1:0] blk;
        bit                named;
        int                last;
        res   = '0;
        named = 1'b0;
        blk   = req.addr - ADDR_W'(req.addr % BLOCK_BYTES);
        case (req.mode)
            MODE_RANGED: begin
                named          = 1'b1;
                res.block_addr = blk;
                last           = int'(region_base) + int'(region_len) - 2;
                if (req.addr >= region_base && int'(req.addr) <= last) begin
                    res.action = save_block(req.addr, 1'b1, blk);
                end
            end
            MODE_CHECK: begin
                named          = 1'b1;
                res.block_addr = blk;
                res.action     = save_block(req.addr, 1'b1, blk);
            end
            MODE_LOG: begin
                named          = 1'b1;
                res.block_addr = blk;
                res.action     = save_block(req.addr, 1'b0, blk);
            end
            MODE_CKPT: begin
                stack_fill = 0;
                bump_epoch();
                res.action = ACT_EPOCH;
            end
            MODE_RBEGIN: begin
                bump_epoch();
                res.action = ACT_EPOCH;
            end
            MODE_RPOP: begin
                if (stack_fill == 0 || stack_fill > LOG_DEPTH) begin
                    res.action = ACT_EMPTY;
                end else begin
                    stack_fill--;
                    res.block_addr = undo_stack[stack_fill];
                    named          = 1'b1;
                    res.action     = ACT_RESTORE;
                end
            end
            default: ;  // spare modes: skip, no state change
        endcase
        if (named) res.shadow_addr = res.block_addr - shadow_dist;
        res.log_count = COUNT_W'(stack_fill);
        res.epoch_now = cur_epoch;
        return res;
    endfunction

    // Retire results, then record new requests, then track register writes
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            region_base = '0;
            region_len  = SIZE_W'(2048);
            shadow_dist = '0;
            cur_epoch   = EPOCH_ONE;
            foreach (block_tag[i]) block_tag[i] = '0;
            stack_fill  = 0;
            tracker_outcomes.delete();
            n_issued  <= 0;
            n_retired <= 0;
            n_bad     <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (tracker_outcomes.size() == 0) begin
                    if (n_bad < 10) begin
                        $display("%0t: result transaction with nothing outstanding: %p",
                                 $realtime, m_data);
                    end
                    n_bad <= n_bad + 1;
                end else begin
                    want = tracker_outcomes.pop_front();
                    n_retired <= n_retired + 1;
                    if (want.action !== m_data.action ||
                        want.block_addr !== m_data.block_addr ||
                        want.shadow_addr !== m_data.shadow_addr ||
                        want.log_count !== m_data.log_count ||
                        want.epoch_now !== m_data.epoch_now) begin
                        if (n_bad < 10) begin
                            $display({"%0t: mismatch: expected action=%0d block=%h shadow=%h ",
                                      "count=%0d epoch=%0d, got action=%0d block=%h ",
                                      "shadow=%h count=%0d epoch=%0d"},
                                     $realtime, want.action, want.block_addr,
                                     want.shadow_addr, want.log_count, want.epoch_now,
                                     m_data.action, m_data.block_addr, m_data.shadow_addr,
                                     m_data.log_count, m_data.epoch_now);
                        end
                        n_bad <= n_bad + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                tracker_outcomes.push_back(track_store(s_data));
                n_issued <= n_issued + 1;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_REGION_START:  region_base = cfg_wdata;
                    REG_REGION_SIZE:   region_len  = cfg_wdata[SIZE_W-1:0];
                    REG_SHADOW_OFFSET: shadow_dist = cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

[tb/sv/undo_log_write_tracker_unit_tb.sv]
// Stimulus and verdict for the write tracker; checking lives in the checker.
module undo_log_write_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ulwt_pkg::*;

    localparam int MAP_SLOTS   = 256;
    localparam int LOG_SLOTS   = 2048;
    localparam int BLOCK_SIZE  = 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 16;

    // Modes and register index that the package leaves unnamed
    localparam logic [MODE_W-1:0]    MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0]    MODE_SPARE_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b1;
    out_item_t             m_data;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned cycles = 0;

    // Region as last loaded, used to aim addresses
    logic [ADDR_W-1:0] region_lo  = '0;
    logic [SIZE_W-1:0] region_len = SIZE_W'(2048);
    bit                quiet      = 1'b0;

    undo_log_write_tracker_unit #(
        .MAP_ENTRIES (MAP_SLOTS),
        .LOG_DEPTH   (LOG_SLOTS),
        .BLOCK_BYTES (BLOCK_SIZE)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    undo_log_write_tracker_checker #(
        .MAP_ENTRIES (MAP_SLOTS),
        .LOG_DEPTH   (LOG_SLOTS),
        .BLOCK_BYTES (BLOCK_SIZE)
    ) tracker_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side back-pressure in random bursts
    initial begin
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    // One request transaction, with an optional idle burst ahead of it
    task automatic send(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr);
        in_item_t req;
        req.mode = mode;
        req.addr = addr;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off until every outstanding result has come back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_region(input logic [ADDR_W-1:0] start, input logic [SIZE_W-1:0] size,
                               input logic [ADDR_W-1:0] offset);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_REGION_START;
        cfg_wdata <= start;
        @(posedge aclk);
        cfg_index <= REG_REGION_SIZE;
        cfg_wdata <= CFG_DATA_W'(size);
        @(posedge aclk);
        cfg_index <= REG_SHADOW_OFFSET;
        cfg_wdata <= offset;
        @(posedge aclk);
        cfg_index <= REG_SPARE;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        region_lo  = start;
        region_len = size;
    endtask

    // Mostly around the region, some on a few hot blocks, the rest anywhere
    function automatic logic [ADDR_W-1:0] aim_addr();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return region_lo + ADDR_W'($urandom_range(0, int'(region_len) + 15)) - 16'd8;
        if (k < 8) return region_lo + ADDR_W'(8 * $urandom_range(0, 7) + $urandom_range(0, 7));
        return ADDR_W'($urandom);
    endfunction

    task automatic send_random();
        int r;
        logic [MODE_W-1:0] mode;
        r = $urandom_range(0, 99);
        if (r < 28)      mode = MODE_RANGED;
        else if (r < 48) mode = MODE_CHECK;
        else if (r < 58) mode = MODE_LOG;
        else if (r < 63) mode = MODE_CKPT;
        else if (r < 69) mode = MODE_RBEGIN;
        else if (r < 94) mode = MODE_RPOP;
        else if (r < 97) mode = MODE_SPARE_LO;
        else             mode = MODE_SPARE_HI;
        send(mode, aim_addr());
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] start, input logic [SIZE_W-1:0] size,
                             input logic [ADDR_W-1:0] offset, input int count);
        settle();
        load_region(start, size, offset);
        repeat (count) send_random();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed checks on the reset configuration: whole low 2 KiB region
        send(MODE_RANGED, 16'h0000);    // first block, backed up
        send(MODE_RANGED, 16'h07FE);    // last accepted address, last map entry
        send(MODE_RANGED, 16'h07FF);    // one past the ranged limit
        send(MODE_RANGED, 16'h0003);    // same block again, already tagged
        send(MODE_RANGED, 16'hFFFF);    // below the region after wrap
        send(MODE_CHECK,  16'hFFFF);    // outside the map: logged, not tagged
        send(MODE_CHECK,  16'hFFFF);    // so logged again
        send(MODE_CHECK,  16'h0800);    // first index past the map
        send(MODE_LOG,    16'h0005);    // unconditional log of a tagged block
        send(MODE_CHECK,  16'h0007);    // tagged block skipped
        send(MODE_SPARE_LO, 16'hFFFF);
        send(MODE_SPARE_HI, 16'h1234);
        repeat (7) send(MODE_RPOP, 16'hFFFF);   // drain the log and pop it empty
        send(MODE_RBEGIN, 16'hFFFF);
        send(MODE_CHECK,  16'h0000);    // new epoch, backed up again
        send(MODE_CKPT,   16'h0000);
        send(MODE_RPOP,   16'h0000);    // checkpoint left the log empty
        send(MODE_RANGED, 16'h0000);

        // Random traffic over a range of settings, extremes first
        run_phase(16'h1000, 12'd64,   16'h0800, 20);
        run_phase(16'hFFFF, 12'd0,    16'hFFFF, 20);
        run_phase(16'h2000, 12'd1,    16'h0000, 20);
        run_phase(16'h3000, 12'd2,    16'h7FF8, 20);
        run_phase(16'hFF00, 12'd4095, 16'h1234, 20);

        // Grow the undo log, then pop it back down past empty
        settle();
        load_region(16'h4000, 12'd2048, 16'h0100);
        send(MODE_CKPT, ADDR_W'($urandom));
        repeat (40) send(MODE_LOG, ADDR_W'($urandom));
        repeat (12) send(MODE_CHECK, aim_addr());
        repeat (60) send(MODE_RPOP, ADDR_W'($urandom));
        repeat (4) send(MODE_LOG, aim_addr());
        send(MODE_CKPT, ADDR_W'($urandom));

        // Enough epoch steps to wrap, with write checks on hot blocks between
        settle();
        load_region(16'h8000, 12'd256, 16'hA000);
        for (int i = 0; i < 340; i++) begin
            if (i % 4 == 3) begin
                send($urandom_range(0, 1) ? MODE_CHECK : MODE_RANGED,
                     region_lo + ADDR_W'(8 * $urandom_range(0, 31) + $urandom_range(0, 7)));
            end else begin
                send($urandom_range(0, 1) ? MODE_CKPT : MODE_RBEGIN, ADDR_W'($urandom));
            end
        end

        run_phase(16'h0000, 12'd2048, 16'h0000, 20);
        repeat (3) run_phase(ADDR_W'($urandom), SIZE_W'($urandom_range(2, 2048)),
                             ADDR_W'($urandom), 15);

        // Closing stretch at full rate on both sides
        quiet = 1'b1;
        run_phase(ADDR_W'($urandom), SIZE_W'($urandom_range(2, 2048)), ADDR_W'($urandom), 25);

        settle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
